@@ src/c2rgb_pkg.sv @@
// Shared types, constants and lookup functions for the color text parser.
// Holds the palette name and color tables and the small helpers that read them.
// No dependencies; used by c2rgb_names and color_text_to_rgb565.
package c2rgb_pkg;

   // Block sizes and limits
   localparam int unsigned PALETTE_MAX       = 24;
   localparam int unsigned PALETTE_NAMES_DEF = 24;
   localparam int unsigned HEX_DIGITS        = 6;
   localparam int unsigned NAME_BITS         = 80;
   localparam int unsigned WORD_BITS         = 88;

   localparam logic [3:0]  COUNT_MAX       = 4'd15;
   localparam logic [3:0]  WORD_LEN        = 4'd11;
   localparam logic [3:0]  SHORT_HEX_COUNT = 4'd4;
   localparam logic [3:0]  LONG_HEX_COUNT  = 4'd7;

   // Character codes
   localparam logic [7:0]  NUL_CHAR     = 8'h00;
   localparam logic [7:0]  HASH_CHAR    = 8'h23;
   localparam logic [7:0]  UPPER_A_CHAR = 8'h41;
   localparam logic [7:0]  UPPER_F_CHAR = 8'h46;
   localparam logic [7:0]  UPPER_Z_CHAR = 8'h5A;
   localparam logic [7:0]  LOWER_A_CHAR = 8'h61;
   localparam logic [7:0]  LOWER_F_CHAR = 8'h66;
   localparam logic [7:0]  DIGIT_0_CHAR = 8'h30;
   localparam logic [7:0]  DIGIT_9_CHAR = 8'h39;
   localparam logic [7:0]  CASE_OFFSET  = 8'h20;

   localparam logic [15:0] MAGENTA_565 = 16'hF81F;

   localparam logic [WORD_BITS-1:0] WORD_STR = "transparent";

   // Palette names, right-justified with the first character highest
   localparam logic [NAME_BITS-1:0] NAME_STR [PALETTE_MAX] = '{
      "black", "white", "grey", "gray", "darkgrey", "darkgray",
      "lightgrey", "lightgray", "red", "darkred", "lightred", "brown",
      "darkbrown", "lightbrown", "orange", "yellow", "green", "darkgreen",
      "lightgreen", "blue", "darkblue", "lightblue", "purple", "pink"
   };

   localparam logic [3:0] NAME_LEN [PALETTE_MAX] = '{
      4'd5, 4'd5, 4'd4, 4'd4, 4'd8, 4'd8,
      4'd9, 4'd9, 4'd3, 4'd7, 4'd8, 4'd5,
      4'd9, 4'd10, 4'd6, 4'd6, 4'd5, 4'd9,
      4'd10, 4'd4, 4'd8, 4'd9, 4'd6, 4'd4
   };

   localparam logic [23:0] NAME_RGB [PALETTE_MAX] = '{
      24'h000000, 24'hffffff, 24'h9d9d9d, 24'h9d9d9d, 24'h697175, 24'h697175,
      24'hcccccc, 24'hcccccc, 24'hbe2633, 24'h732930, 24'he06f8b, 24'ha46422,
      24'h493c2b, 24'heeb62f, 24'heb8931, 24'hf7e26b, 24'h44891a, 24'h2f484e,
      24'ha3ce27, 24'h1d57f7, 24'h1b2632, 24'hb2dcef, 24'h342a97, 24'hde65e2
   };

   // Match results handed from the name matcher to the top level
   typedef struct packed {
      logic        transp_hit;
      logic        name_hit;
      logic [15:0] name_color;
   } name_hit_type;

   // Number of palette entries in use; larger requests stop at the table size
   function automatic int unsigned used_names(input int unsigned n);
      return (n > PALETTE_MAX) ? PALETTE_MAX : n;
   endfunction

   // Drop low bits of each channel to form 5-6-5
   function automatic logic [15:0] pack565(input logic [23:0] rgb);
      return {rgb[23:19], rgb[15:10], rgb[7:3]};
   endfunction

   // Fold A to Z onto lower case, leave all other bytes alone
   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= UPPER_A_CHAR && c <= UPPER_Z_CHAR) ? c + CASE_OFFSET : c;
   endfunction

   // Character of a palette name at a position, zero past its end
   function automatic logic [7:0] name_char(input int unsigned idx, input logic [3:0] pos);
      logic [NAME_BITS-1:0] text;
      logic [3:0]           len;
      logic [3:0]           back;
      text = NAME_STR[idx];
      len  = NAME_LEN[idx];
      back = len - 4'd1 - pos;
      if (pos >= len) begin
         return NUL_CHAR;
      end
      return text[{back, 3'b000} +: 8];
   endfunction

   // Character of the transparent keyword at a position, zero past its end
   function automatic logic [7:0] word_char(input logic [3:0] pos);
      logic [3:0] back;
      back = WORD_LEN - 4'd1 - pos;
      if (pos >= WORD_LEN) begin
         return NUL_CHAR;
      end
      return WORD_STR[{back, 3'b000} +: 8];
   endfunction

   // Hex digit decode: bit 4 flags a byte that is not a hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= DIGIT_0_CHAR && c <= DIGIT_9_CHAR) begin
         v = c - DIGIT_0_CHAR;
         return {1'b0, v[3:0]};
      end
      if (c >= LOWER_A_CHAR && c <= LOWER_F_CHAR) begin
         v = c - LOWER_A_CHAR + 8'd10;
         return {1'b0, v[3:0]};
      end
      if (c >= UPPER_A_CHAR && c <= UPPER_F_CHAR) begin
         v = c - UPPER_A_CHAR + 8'd10;
         return {1'b0, v[3:0]};
      end
      return 5'b1_0000;
   endfunction

endpackage

@@ src/c2rgb_names.sv @@
// Name matcher: compares one lowered character against the keyword and palette names.
// Produces the next match vector and the end-of-text hit and palette color.
// Depends on c2rgb_pkg.
module c2rgb_names #(
   parameter int unsigned PALETTE_NAMES = c2rgb_pkg::PALETTE_NAMES_DEF,
   localparam int unsigned NAMES_USED = c2rgb_pkg::used_names(PALETTE_NAMES)
) (
   input  logic                      [7:0] char_lc,
   input  logic                      [3:0] char_pos,
   input  logic             [NAMES_USED:0] match_cur,
   output logic             [NAMES_USED:0] match_next,
   output c2rgb_pkg::name_hit_type         hit
);

   // Keep a candidate alive only while every character lines up
   always_comb begin
      match_next[0] = match_cur[0] && (char_pos < c2rgb_pkg::WORD_LEN) &&
                      (char_lc == c2rgb_pkg::word_char(char_pos));
      for (int i = 0; i < int'(NAMES_USED); i++) begin
         match_next[i+1] = match_cur[i+1] &&
                           (char_pos < c2rgb_pkg::NAME_LEN[i]) &&
                           (char_lc == c2rgb_pkg::name_char(i, char_pos));
      end
   end

   // At end of text: first surviving name whose length equals the count wins
   always_comb begin
      hit.transp_hit = match_cur[0] && (char_pos == c2rgb_pkg::WORD_LEN);
      hit.name_hit   = 1'b0;
      hit.name_color = c2rgb_pkg::MAGENTA_565;
      for (int i = int'(NAMES_USED) - 1; i >= 0; i--) begin
         if (match_cur[i+1] && (char_pos == c2rgb_pkg::NAME_LEN[i])) begin
            hit.name_hit   = 1'b1;
            hit.name_color = c2rgb_pkg::pack565(c2rgb_pkg::NAME_RGB[i]);
         end
      end
   end

endmodule

@@ src/color_text_to_rgb565.sv @@
// Color text parser top level: input register, per-character state, result register.
// Turns a zero-terminated color string into an RGB565 value and a transparent flag.
// Depends on c2rgb_pkg and c2rgb_names.
//
// Usage:
//   req_* carries one character per transfer in req_tdata[7:0]. A zero byte ends
//   the string; only that byte produces a result. Nonzero bytes only update state.
//   rsp_* carries one result per string: rsp_tdata[15:0] is the RGB565 color
//   (0xF81F when not recognized), rsp_tuser is set for "transparent".
//   Result path: the zero byte is taken into the input register, then its result
//   is loaded into the result register, from which it can transfer on rsp_*.
//   Throughput: one character per cycle, back to back, including terminators,
//   as long as the receiver takes results. The per-character state registers
//   form a loop that folds each character in fully as it leaves the input register.
//   Stall: a result waits in the result register; the next string's characters
//   keep flowing in. A second terminator waits in the input register until the
//   result register frees, and req_tready drops while it waits.
//   Reset: synchronous, active high; clears both channels and the parse state.
module color_text_to_rgb565 #(
   parameter int unsigned PALETTE_NAMES = c2rgb_pkg::PALETTE_NAMES_DEF,
   localparam int unsigned NAMES_USED = c2rgb_pkg::used_names(PALETTE_NAMES)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic  [7:0] req_tdata,   // [7:0] char_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] rgb565_color
   output logic        rsp_tuser    // [0] is_transparent
);

   logic                   in_valid_ff;
   logic             [7:0] in_char_ff;
   logic                   in_adv;
   logic                   in_end;
   logic                   out_free;
   logic                   out_load;

   logic             [3:0] count_ff;
   logic                   hash_ff;
   logic                   hex_valid_ff;
   logic             [3:0] hex_dig_ff [c2rgb_pkg::HEX_DIGITS];
   logic    [NAMES_USED:0] match_ff;
   logic    [NAMES_USED:0] match_in;

   logic             [7:0] char_lc;
   logic             [4:0] nib;
   c2rgb_pkg::name_hit_type hit;

   logic            [15:0] color_in;
   logic                   transp_in;

   logic                   rsp_valid_ff;
   logic            [15:0] rsp_color_ff;
   logic                   rsp_transp_ff;

   // Handshake: a character moves on unless it ends a string and the result is held
   assign in_end     = (in_char_ff == c2rgb_pkg::NUL_CHAR);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_adv     = in_valid_ff && (!in_end || out_free);
   assign out_load   = in_adv && in_end;
   assign req_tready = !in_valid_ff || in_adv;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
   end

   assign char_lc = c2rgb_pkg::to_lower(in_char_ff);
   assign nib     = c2rgb_pkg::hex_nibble(in_char_ff);

   c2rgb_names #(
      .PALETTE_NAMES (PALETTE_NAMES)
   ) u_names (
      .char_lc    (char_lc),
      .char_pos   (count_ff),
      .match_cur  (match_ff),
      .match_next (match_in),
      .hit        (hit)
   );

   // Fold one character into the parse state; clear it once a string ends
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hash_ff      <= 1'b0;
         hex_valid_ff <= 1'b1;
         match_ff     <= '1;
      end else if (in_adv) begin
         if (in_end) begin
            count_ff     <= '0;
            hash_ff      <= 1'b0;
            hex_valid_ff <= 1'b1;
            match_ff     <= '1;
         end else begin
            match_ff <= match_in;
            if (count_ff == 4'd0) begin
               hash_ff <= (in_char_ff == c2rgb_pkg::HASH_CHAR);
            end else if (count_ff <= 4'(c2rgb_pkg::HEX_DIGITS) && nib[4]) begin
               hex_valid_ff <= 1'b0;
            end
            if (count_ff < c2rgb_pkg::COUNT_MAX) begin
               count_ff <= count_ff + 4'd1;
            end
         end
      end
   end

   // Capture hex digits at positions one to six; bad digits store zero
   always_ff @(posedge clock) begin
      for (int i = 0; i < int'(c2rgb_pkg::HEX_DIGITS); i++) begin
         if (in_adv && !in_end && count_ff == 4'(i + 1)) begin
            hex_dig_ff[i] <= nib[4] ? 4'd0 : nib[3:0];
         end
      end
   end

   // Pick the result: keyword, then hex forms, then palette names
   always_comb begin
      color_in  = c2rgb_pkg::MAGENTA_565;
      transp_in = 1'b0;
      priority if (count_ff == 4'd0) begin
         color_in = c2rgb_pkg::MAGENTA_565;
      end else if (hit.transp_hit) begin
         color_in  = 16'h0000;
         transp_in = 1'b1;
      end else if (hash_ff) begin
         if (hex_valid_ff && count_ff == c2rgb_pkg::SHORT_HEX_COUNT) begin
            color_in = {hex_dig_ff[0], hex_dig_ff[0][3],
                        hex_dig_ff[1], hex_dig_ff[1][3:2],
                        hex_dig_ff[2], hex_dig_ff[2][3]};
         end else if (hex_valid_ff && count_ff == c2rgb_pkg::LONG_HEX_COUNT) begin
            color_in = {hex_dig_ff[0], hex_dig_ff[1][3],
                        hex_dig_ff[2], hex_dig_ff[3][3:2],
                        hex_dig_ff[4], hex_dig_ff[5][3]};
         end
      end else if (hit.name_hit) begin
         color_in = hit.name_color;
      end else begin
         color_in = c2rgb_pkg::MAGENTA_565;
      end
   end

   // Result register: load on a string end, drop once the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_color_ff  <= color_in;
         rsp_transp_ff <= transp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_transp_ff;

`ifndef SYNTHESIS
   // A string end leaves the parse state at its start values
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (count_ff == 4'd0) && (match_ff == '1) && !hash_ff && hex_valid_ff)
      else $error("parse state not cleared after string end");

   // Transparent results always carry color zero
   a_transp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 16'h0000))
      else $error("transparent result with nonzero color");

   // A new result appears only after a terminator moved on
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(out_load))
      else $error("result appeared without a string end");

   // A held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !out_load)
      else $error("result register loaded while stalled");

   // With no characters counted, every candidate is still alive
   a_start_state: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 4'd0) |-> (match_ff == '1) && hex_valid_ff)
      else $error("candidates lost before any character");
`endif

endmodule
